// File: src/mbrtu_pkg.sv
package mbrtu_pkg;

  // Fixed protocol constants
  localparam logic [7:0]  FUNC_CODE = 8'h46;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Position of the byte being sent within the current command
  typedef logic [3:0] step_t;

  localparam step_t STEP_SLAVE   = 4'd0;
  localparam step_t STEP_FUNC    = 4'd1;
  localparam step_t STEP_ADDR_HI = 4'd2;
  localparam step_t STEP_ADDR_LO = 4'd3;
  localparam step_t STEP_CNT_HI  = 4'd4;
  localparam step_t STEP_CNT_LO  = 4'd5;
  localparam step_t STEP_BODY    = 4'd6;  // length byte of a header, or one data byte
  localparam step_t STEP_CRC_LO  = 4'd7;
  localparam step_t STEP_CRC_HI  = 4'd8;

  // Classified item handed from front to back
  typedef struct packed {
    logic        is_start;  // header command, else one data byte
    logic        closes;    // CRC bytes follow the body byte
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [7:0]  body;      // clamped length or data byte
  } cmd_t;

  // CRC-16/MODBUS update by one byte, reflected
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/modbus_rtu_write_frame_builder.sv
// Modbus RTU request builder for function 0x46 with CRC-16/MODBUS. A start
// item (kind 0) produces seven header bytes (slave, 0x46, address hi/lo,
// count hi/lo, clamped length) and, if the length is zero, the two CRC bytes
// at once; each data item (kind 1) inside an open frame produces its byte and,
// on the last one, CRC low then CRC high with frame_end set. Data items with
// no open frame are dropped; a new start abandons an open frame. The output
// serializer sends one byte per cycle while out_stall_i is low, so data items
// sustain one per cycle unless stalled; a start item holds the output for its
// header bytes (and CRC bytes at zero length). Items are classified on entry,
// queued in a QUEUE_DEPTH-entry queue; in_stall_o rises only while it is full.
module modbus_rtu_write_frame_builder import mbrtu_pkg::*; #(
  parameter int MAX_PAYLOAD = 246,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  slave_address_i,
  input  logic [15:0] register_address_i,
  input  logic [15:0] register_count_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_end_o
);

  logic accept, push, pop, q_empty, q_full;
  cmd_t cmd_in, cmd_head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Classify items
  mbrtu_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .kind_i             (kind_i),
    .slave_address_i    (slave_address_i),
    .register_address_i (register_address_i),
    .register_count_i   (register_count_i),
    .payload_length_i   (payload_length_i),
    .payload_byte_i     (payload_byte_i),
    .push_o             (push),
    .cmd_o              (cmd_in)
  );

  // Command queue
  mbrtu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .head_o  (cmd_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Byte serializer and CRC
  mbrtu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!q_empty),
    .cmd_i        (cmd_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// File: src/mbrtu_front.sv
module mbrtu_front import mbrtu_pkg::*; #(
  parameter int MAX_PAYLOAD = 246
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        kind_i,
  input  logic [7:0]  slave_address_i,
  input  logic [15:0] register_address_i,
  input  logic [15:0] register_count_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  payload_byte_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [7:0] remaining_q, remaining_d;
  logic       open_q, open_d;
  logic [7:0] len_clamped;
  logic       in_frame;

  assign len_clamped = (payload_length_i > MaxLen) ? MaxLen : payload_length_i;
  assign in_frame    = open_q && (remaining_q != 8'd0);

  // Classify the item and track the open frame
  always_comb begin
    remaining_d = remaining_q;
    open_d      = open_q;
    push_o      = 1'b0;
    cmd_o.is_start = ~kind_i;
    cmd_o.slave    = slave_address_i;
    cmd_o.addr     = register_address_i;
    cmd_o.cnt      = register_count_i;
    cmd_o.body     = kind_i ? payload_byte_i : len_clamped;
    cmd_o.closes   = kind_i ? (remaining_q == 8'd1) : (len_clamped == 8'd0);
    if (accept_i) begin
      if (!kind_i) begin
        push_o      = 1'b1;
        remaining_d = len_clamped;
        open_d      = (len_clamped != 8'd0);
      end else if (in_frame) begin
        push_o      = 1'b1;
        remaining_d = remaining_q - 8'd1;
        open_d      = (remaining_q != 8'd1);
      end else begin
        // data byte with no frame open: dropped
        remaining_d = 8'd0;
        open_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= 8'd0;
      open_q      <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      open_q      <= open_d;
    end
  end

endmodule

// File: src/mbrtu_queue.sv
module mbrtu_queue import mbrtu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(DEPTH));
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: src/mbrtu_back.sv
module mbrtu_back import mbrtu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o
);

  logic        cur_valid_q, cur_valid_d;
  cmd_t        cur_q;
  step_t       step_q, step_d;
  logic [15:0] crc_q, crc_d, crc_base;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        end_q;

  logic        advance, act_valid, fire;
  cmd_t        act_cmd;
  step_t       act_step;
  logic [7:0]  act_byte;

  // Current command: held one, or queue head with its first step
  assign advance   = !out_valid_q || !out_stall_i;
  assign act_valid = cur_valid_q || cmd_valid_i;
  assign act_cmd   = cur_valid_q ? cur_q : cmd_i;
  assign act_step  = cur_valid_q ? step_q : (cmd_i.is_start ? STEP_SLAVE : STEP_BODY);
  assign fire      = advance && act_valid;
  assign pop_o     = fire && !cur_valid_q;

  // Byte select
  always_comb begin
    case (act_step)
      STEP_SLAVE:   act_byte = act_cmd.slave;
      STEP_FUNC:    act_byte = FUNC_CODE;
      STEP_ADDR_HI: act_byte = act_cmd.addr[15:8];
      STEP_ADDR_LO: act_byte = act_cmd.addr[7:0];
      STEP_CNT_HI:  act_byte = act_cmd.cnt[15:8];
      STEP_CNT_LO:  act_byte = act_cmd.cnt[7:0];
      STEP_BODY:    act_byte = act_cmd.body;
      STEP_CRC_LO:  act_byte = crc_q[7:0];
      STEP_CRC_HI:  act_byte = crc_q[15:8];
      default:      act_byte = 8'h00;
    endcase
  end

  // Step sequencing and CRC update
  assign crc_base = (act_step == STEP_SLAVE) ? CRC_INIT : crc_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    step_d      = step_q;
    crc_d       = crc_q;
    if (fire) begin
      cur_valid_d = 1'b1;
      step_d      = act_step + 4'd1;
      case (act_step)
        STEP_BODY: begin
          crc_d = crc16_fold(crc_base, act_byte);
          if (!act_cmd.closes) begin
            cur_valid_d = 1'b0;
          end
        end
        STEP_CRC_LO: begin
          crc_d = crc_q;
        end
        STEP_CRC_HI: begin
          crc_d       = CRC_INIT;
          cur_valid_d = 1'b0;
        end
        default: begin
          crc_d = crc16_fold(crc_base, act_byte);
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
    if (fire) begin
      byte_q <= act_byte;
      end_q  <= (act_step == STEP_CRC_HI);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= STEP_SLAVE;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      step_q      <= step_d;
      crc_q       <= crc_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (advance) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign frame_end_o  = end_q;

endmodule

// File: bench/mbrtu_tb_pkg.sv
`timescale 1ns / 100ps

package mbrtu_tb_pkg;

  // Item kinds on the input channel
  localparam logic KIND_START = 1'b0;  // header fields, opens a frame
  localparam logic KIND_DATA  = 1'b1;  // one payload byte

endpackage

// File: bench/frame_checker.sv
`timescale 1ns / 100ps

module frame_checker import mbrtu_pkg::*; import mbrtu_tb_pkg::*; #(
  parameter int MAX_PAYLOAD = 246
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  slave_address_i,
  input  logic [15:0] register_address_i,
  input  logic [15:0] register_count_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  output int          mismatch_count_o,
  output int          bytes_pending_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       is_end;
  } frame_byte_t;

  // Bytes the block still owes, oldest first
  frame_byte_t bytes_due[$];

  // Shadow of the frame state
  logic [15:0] running_crc;
  logic [7:0]  payload_left;
  logic        frame_open;
  int          errors;

  // CRC-16/MODBUS, one data bit at a time, LSB first
  function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        feedback;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      feedback = acc[0] ^ b[i];
      acc = {1'b0, acc[15:1]};
      if (feedback) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic queue_byte(input logic [7:0] value, input logic is_end);
    frame_byte_t fb;
    fb.value  = value;
    fb.is_end = is_end;
    bytes_due.push_back(fb);
    running_crc = crc_after(running_crc, value);
  endtask

  // CRC low then high; high byte ends the frame
  task automatic close_frame();
    logic [15:0] final_crc;
    final_crc = running_crc;
    queue_byte(final_crc[7:0], 1'b0);
    queue_byte(final_crc[15:8], 1'b1);
    running_crc  = CRC_INIT;
    payload_left = '0;
    frame_open   = 1'b0;
  endtask

  task automatic predict_item();
    logic [7:0] len;
    if (kind_i == KIND_START) begin
      // new header; an open frame is simply abandoned
      len = (payload_length_i > MAX_PAYLOAD) ? 8'(MAX_PAYLOAD) : payload_length_i;
      running_crc = CRC_INIT;
      queue_byte(slave_address_i, 1'b0);
      queue_byte(FUNC_CODE, 1'b0);
      queue_byte(register_address_i[15:8], 1'b0);
      queue_byte(register_address_i[7:0], 1'b0);
      queue_byte(register_count_i[15:8], 1'b0);
      queue_byte(register_count_i[7:0], 1'b0);
      queue_byte(len, 1'b0);
      if (len == 8'd0) begin
        close_frame();
      end else begin
        payload_left = len;
        frame_open   = 1'b1;
      end
    end else if (frame_open && payload_left != 8'd0) begin
      queue_byte(payload_byte_i, 1'b0);
      payload_left = payload_left - 8'd1;
      if (payload_left == 8'd0) begin
        close_frame();
      end
    end else begin
      // stray payload byte: dropped
      payload_left = '0;
      frame_open   = 1'b0;
    end
  endtask

  task automatic check_byte();
    frame_byte_t want;
    if (bytes_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("frame_checker: unexpected byte %02h end %0b at %0t",
                 frame_byte_i, frame_end_i, $realtime);
      end
    end else begin
      want = bytes_due.pop_front();
      if (frame_byte_i !== want.value || frame_end_i !== want.is_end) begin
        errors++;
        if (errors <= 10) begin
          $display("frame_checker: at %0t byte exp %02h got %02h, end exp %0b got %0b",
                   $realtime, want.value, frame_byte_i, want.is_end, frame_end_i);
        end
      end
    end
  endtask

  // Input side predicts, output side compares
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_due.delete();
      running_crc  = CRC_INIT;
      payload_left = '0;
      frame_open   = 1'b0;
      errors       = 0;
      mismatch_count_o <= 0;
      bytes_pending_o  <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_item();
      end
      if (out_valid_i && !out_stall_i) begin
        check_byte();
      end
      mismatch_count_o <= errors;
      bytes_pending_o  <= bytes_due.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top import mbrtu_tb_pkg::*;;

  localparam int MAX_PAYLOAD = 246;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic        kind_i             = KIND_START;
  logic [7:0]  slave_address_i    = '0;
  logic [15:0] register_address_i = '0;
  logic [15:0] register_count_i   = '0;
  logic [7:0]  payload_length_i   = '0;
  logic [7:0]  payload_byte_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        frame_end_o;

  int mismatches;
  int bytes_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;

  modbus_rtu_write_frame_builder #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .slave_address_i    (slave_address_i),
    .register_address_i (register_address_i),
    .register_count_i   (register_count_i),
    .payload_length_i   (payload_length_i),
    .payload_byte_i     (payload_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_byte_o       (frame_byte_o),
    .frame_end_o        (frame_end_o)
  );

  frame_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) frame_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .kind_i             (kind_i),
    .slave_address_i    (slave_address_i),
    .register_address_i (register_address_i),
    .register_count_i   (register_count_i),
    .payload_length_i   (payload_length_i),
    .payload_byte_i     (payload_byte_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_byte_i       (frame_byte_o),
    .frame_end_i        (frame_end_o),
    .mismatch_count_o   (mismatches),
    .bytes_pending_o    (bytes_pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Random back-pressure on the frame output
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // One item: optional idle gap, then hold until accepted
  task automatic send_item(input logic kind, input logic [7:0] slave,
                           input logic [15:0] addr, input logic [15:0] cnt,
                           input logic [7:0] len, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    kind_i             <= kind;
    slave_address_i    <= slave;
    register_address_i <= addr;
    register_count_i   <= cnt;
    payload_length_i   <= len;
    payload_byte_i     <= data;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  // Unused fields carry random junk
  task automatic send_start(input logic [7:0] slave, input logic [15:0] addr,
                            input logic [15:0] cnt, input logic [7:0] len);
    send_item(KIND_START, slave, addr, cnt, len, 8'($urandom));
  endtask

  task automatic send_data(input logic [7:0] data);
    send_item(KIND_DATA, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), data);
  endtask

  // Hold off the sender until every owed byte has come out
  task automatic drain_output();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (bytes_pending != 0);
  endtask

  // Mostly well-formed frames, some cut short, some stray bytes
  task automatic random_frame();
    int pick;
    int len;
    int count;
    pick = $urandom_range(99);
    if (pick < 12) begin
      len = 0;
    end else if (pick < 18) begin
      len = $urandom_range(11, 255);
    end else begin
      len = $urandom_range(1, 10);
    end
    send_start(8'($urandom), 16'($urandom), 16'($urandom), 8'(len));
    count = len;
    if (len > 10) begin
      count = $urandom_range(2, 12);  // long frames are mostly abandoned early
    end else if ($urandom_range(99) < 10) begin
      count = $urandom_range(0, len);
    end
    repeat (count) send_data(8'($urandom));
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 3)) send_data(8'($urandom));
    end
    if ($urandom_range(99) < 8) begin
      drain_output();
    end
  endtask

  task automatic random_phase(input int sender_pct, input int receiver_pct);
    int phase_end;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    phase_end = items_sent + 88;
    while (items_sent < phase_end) begin
      random_frame();
    end
    drain_output();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero length, stray bytes, clamping, abandon, field extremes
    send_start(8'h00, 16'h0000, 16'h0000, 8'd0);
    send_data(8'h5A);
    send_start(8'hFF, 16'hFFFF, 16'hFFFF, 8'd255);
    send_data(8'hFF);
    send_data(8'h00);
    send_start(8'h01, 16'h8000, 16'h0001, 8'd246);
    send_data(8'h80);
    send_start(8'hA5, 16'h1234, 16'h00FF, 8'd247);
    send_start(8'h11, 16'h0102, 16'h0304, 8'd1);
    send_data(8'h7E);
    send_data(8'h33);
    send_start(8'h7F, 16'h7FFF, 16'h8000, 8'd2);
    send_data(8'h01);
    send_data(8'hFE);
    send_start(8'h80, 16'hFF00, 16'h00FF, 8'd0);
    drain_output();

    random_phase(27, 48);
    random_phase(48, 27);
    random_phase(0, 0);

    drain_output();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && bytes_pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
